>>> sv/bfea_pkg.sv
// shared types and constants for the best-fit extent allocator
// no dependencies; used by the core and the checker of the block
package bfea_pkg;

  localparam int HEAP_GRANULES = 4096;
  localparam int HEAP_AW       = $clog2(HEAP_GRANULES);
  localparam int EXT_DEPTH     = 32;
  localparam int EXT_AW        = $clog2(EXT_DEPTH);
  localparam int CNT_W         = EXT_AW + 1;
  localparam int LEN_W         = 13;
  localparam int OFF_W         = 17;
  localparam int BYTES_W       = 16;
  localparam int ALLOC_W       = LEN_W + 1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_FIT     = 2'd1;
  localparam logic [1:0] ST_BAD_FREE   = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic [HEAP_AW-1:0] start;
    logic [LEN_W-1:0]   len;
  } ext_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ALOOK, S_AFIN, S_SHDN,
    S_FCHK, S_FWALK, S_FDEC, S_SHUP, S_DONE
  } state_t;

endpackage

>>> sv/best_fit_extent_allocator_core.sv
// Best-fit extent allocator: a free-extent table of 32 entries and a
// 4096-entry allocation record, each in a ram with a registered read port.
// An allocate scans the table, one extent read per cycle. An exact fit
// removes its entry and pulls the following entries down. A free walks
// the table; a new extent that has to be inserted pushes the entries
// above it up. One item is in work at a time, and the block returns to
// idle as the result enters the output register. A result waits in the
// output register while the next item is taken. After reset and after
// every heap size write the allocation record is swept clear, and no
// item is accepted during the sweep.
// depends on bfea_pkg and bfea_ram
module best_fit_extent_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [bfea_pkg::BYTES_W-1:0]  in_request_bytes,
  input  logic [bfea_pkg::OFF_W-1:0]    in_free_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfea_pkg::OFF_W-1:0]    out_user_offset,
  output logic [bfea_pkg::LEN_W-1:0]    out_granted_granules,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfea_pkg::LEN_W-1:0]    cfg_heap_size_granules
);

  localparam int AW  = bfea_pkg::HEAP_AW;
  localparam int EW  = bfea_pkg::EXT_AW;
  localparam int CW  = bfea_pkg::CNT_W;
  localparam int LW  = bfea_pkg::LEN_W;
  localparam int OW  = bfea_pkg::OFF_W;

  bfea_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [LW-1:0]  heap_r, heap_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]  need_r, need_nxt;
  logic [OW-1:0]  off_r, off_nxt;
  logic [AW-1:0]  gi_r, gi_nxt;
  logic [LW-1:0]  size_r, size_nxt;
  logic [CW-1:0]  ridx_r, ridx_nxt;
  logic           dv_r, dv_nxt;
  logic [EW-1:0]  daddr_r, daddr_nxt;
  logic           found_r, found_nxt, exact_r, exact_nxt;
  logic [EW-1:0]  best_r, best_nxt;
  logic [AW-1:0]  bstart_r, bstart_nxt;
  logic [LW-1:0]  bdelta_r, bdelta_nxt;
  logic [CW-1:0]  lt_r, lt_nxt;
  bfea_pkg::ext_t prev_r, prev_nxt, next_r, next_nxt;
  logic           hnext_r, hnext_nxt;
  logic [OW-1:0]  res_off_r, res_off_nxt;
  logic [LW-1:0]  res_g_r, res_g_nxt;
  logic [1:0]     res_st_r, res_st_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [OW-1:0]  out_off_r, out_off_nxt;
  logic [LW-1:0]  out_g_r, out_g_nxt;
  logic [1:0]     out_st_r, out_st_nxt;

  // ram ports
  logic                     ext_we;
  logic [EW-1:0]            ext_waddr, ext_raddr;
  bfea_pkg::ext_t           ext_wdata, ext_rdata;
  logic                     alc_we;
  logic [AW-1:0]            alc_waddr, alc_raddr;
  logic [LW:0]              alc_wdata, alc_rdata;

  bfea_ram #(.W($bits(bfea_pkg::ext_t)), .D(bfea_pkg::EXT_DEPTH)) u_ext_ram (
    .clk(clk), .we(ext_we), .waddr(ext_waddr), .wdata(ext_wdata),
    .raddr(ext_raddr), .rdata(ext_rdata)
  );

  bfea_ram #(.W(bfea_pkg::ALLOC_W), .D(bfea_pkg::HEAP_GRANULES)) u_alc_ram (
    .clk(clk), .we(alc_we), .waddr(alc_waddr), .wdata(alc_wdata),
    .raddr(alc_raddr), .rdata(alc_rdata)
  );

  // shared decode
  logic           in_fire, cfg_fire, slot_free;
  logic           up_issue, fw_issue, issue, scan_end;
  logic [OW-1:0]  need_sum;
  logic [LW-1:0]  gi_full, cfg_clamped;
  logic           free_bad;
  logic [AW+1:0]  prev_end, gi_end;
  logic           prev_hit, next_hit;
  logic [LW-1:0]  d_len;

  assign in_ready  = (state_r == bfea_pkg::S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == bfea_pkg::S_IDLE) || (state_r == bfea_pkg::S_CLEAR);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign fw_issue = ridx_r < cnt_r;
  assign up_issue = ridx_r > lt_r;
  assign issue    = (state_r == bfea_pkg::S_SHUP) ? up_issue : fw_issue;
  assign scan_end = !issue && !dv_r;

  assign need_sum = {1'b0, in_request_bytes} + OW'(32);
  assign gi_full  = in_free_offset[OW-1:4] - LW'(1);
  assign free_bad = (in_free_offset[3:0] != 4'd0) || (in_free_offset[OW-1:4] == '0) ||
                    (gi_full >= heap_r);
  assign cfg_clamped = (cfg_heap_size_granules < LW'(2)) ? LW'(2) :
                       (cfg_heap_size_granules > LW'(bfea_pkg::HEAP_GRANULES)) ?
                       LW'(bfea_pkg::HEAP_GRANULES) : cfg_heap_size_granules;

  assign prev_end = {2'b0, prev_r.start} + {1'b0, prev_r.len};
  assign gi_end   = {2'b0, gi_r} + {1'b0, size_r};
  assign prev_hit = (lt_r != '0) && (prev_end == {2'b0, gi_r});
  assign next_hit = hnext_r && (gi_end == {2'b0, next_r.start});
  assign d_len    = ext_rdata.len - need_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfea_pkg::S_CLEAR: begin
        if (cfg_fire) state_nxt = bfea_pkg::S_CLEAR;
        else if (clr_r == '1) state_nxt = bfea_pkg::S_IDLE;
      end
      bfea_pkg::S_IDLE: begin
        if (cfg_fire) state_nxt = bfea_pkg::S_CLEAR;
        else if (in_fire) begin
          if (in_kind == bfea_pkg::KIND_ALLOC) state_nxt = bfea_pkg::S_ALOOK;
          else if (free_bad) state_nxt = bfea_pkg::S_DONE;
          else state_nxt = bfea_pkg::S_FCHK;
        end
      end
      bfea_pkg::S_ALOOK: if (scan_end) state_nxt = bfea_pkg::S_AFIN;
      bfea_pkg::S_AFIN: begin
        if (found_r && bdelta_r == '0) state_nxt = bfea_pkg::S_SHDN;
        else state_nxt = bfea_pkg::S_DONE;
      end
      bfea_pkg::S_SHDN: if (scan_end) state_nxt = bfea_pkg::S_DONE;
      bfea_pkg::S_FCHK: begin
        if (alc_rdata[LW]) state_nxt = bfea_pkg::S_FWALK;
        else state_nxt = bfea_pkg::S_DONE;
      end
      bfea_pkg::S_FWALK: if (scan_end) state_nxt = bfea_pkg::S_FDEC;
      bfea_pkg::S_FDEC: begin
        if (prev_hit || next_hit || cnt_r >= CW'(bfea_pkg::EXT_DEPTH))
          state_nxt = bfea_pkg::S_DONE;
        else state_nxt = bfea_pkg::S_SHUP;
      end
      bfea_pkg::S_SHUP: if (scan_end) state_nxt = bfea_pkg::S_DONE;
      bfea_pkg::S_DONE: if (slot_free) state_nxt = bfea_pkg::S_IDLE;
      default: state_nxt = bfea_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    clr_nxt = clr_r;  heap_nxt = heap_r;  cnt_nxt = cnt_r;
    need_nxt = need_r;  off_nxt = off_r;  gi_nxt = gi_r;  size_nxt = size_r;
    ridx_nxt = ridx_r;  dv_nxt = 1'b0;  daddr_nxt = daddr_r;
    found_nxt = found_r;  exact_nxt = exact_r;  best_nxt = best_r;
    bstart_nxt = bstart_r;  bdelta_nxt = bdelta_r;  lt_nxt = lt_r;
    prev_nxt = prev_r;  next_nxt = next_r;  hnext_nxt = hnext_r;
    res_off_nxt = res_off_r;  res_g_nxt = res_g_r;  res_st_nxt = res_st_r;
    out_off_nxt = out_off_r;  out_g_nxt = out_g_r;  out_st_nxt = out_st_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    ext_we = 1'b0;  ext_waddr = '0;  ext_wdata = '0;
    ext_raddr = ridx_r[EW-1:0];
    alc_we = 1'b0;  alc_waddr = gi_r;  alc_wdata = '0;
    alc_raddr = gi_full[AW-1:0];

    // extent read issue for the scans and shifts
    if (state_r == bfea_pkg::S_SHUP) begin
      ext_raddr = EW'(ridx_r - CW'(1));
    end
    if ((state_r == bfea_pkg::S_ALOOK || state_r == bfea_pkg::S_FWALK ||
         state_r == bfea_pkg::S_SHDN || state_r == bfea_pkg::S_SHUP) && issue) begin
      dv_nxt    = 1'b1;
      daddr_nxt = ext_raddr;
      ridx_nxt  = (state_r == bfea_pkg::S_SHUP) ? ridx_r - CW'(1) : ridx_r + CW'(1);
    end

    case (state_r)
      bfea_pkg::S_CLEAR: begin
        // sweep the allocation record, keep entry 0 of the table whole
        alc_we    = 1'b1;
        alc_waddr = clr_r;
        ext_we    = 1'b1;
        ext_wdata = '{start: '0, len: heap_r};
        clr_nxt   = clr_r + AW'(1);
        cnt_nxt   = CW'(1);
        if (cfg_fire) begin
          heap_nxt = cfg_clamped;
          clr_nxt  = '0;
        end
      end
      bfea_pkg::S_IDLE: begin
        ridx_nxt = '0;  found_nxt = 1'b0;  exact_nxt = 1'b0;
        lt_nxt = '0;  hnext_nxt = 1'b0;  bdelta_nxt = '0;
        need_nxt = need_sum[OW-1:4];
        off_nxt  = in_free_offset;
        gi_nxt   = gi_full[AW-1:0];
        res_off_nxt = '0;  res_g_nxt = '0;  res_st_nxt = bfea_pkg::ST_BAD_FREE;
        if (cfg_fire) begin
          heap_nxt = cfg_clamped;
          clr_nxt  = '0;
        end
      end
      bfea_pkg::S_ALOOK: begin
        // best fit tracking, first exact fit wins
        if (dv_r && !exact_r) begin
          if (ext_rdata.len == need_r) begin
            best_nxt = daddr_r;  bstart_nxt = ext_rdata.start;
            bdelta_nxt = '0;  found_nxt = 1'b1;  exact_nxt = 1'b1;
          end else if (ext_rdata.len > need_r && (!found_r || d_len < bdelta_r)) begin
            best_nxt = daddr_r;  bstart_nxt = ext_rdata.start;
            bdelta_nxt = d_len;  found_nxt = 1'b1;
          end
        end
      end
      bfea_pkg::S_AFIN: begin
        res_st_nxt = bfea_pkg::ST_NO_FIT;
        res_off_nxt = '0;  res_g_nxt = '0;
        ridx_nxt = CW'(best_r) + CW'(1);
        if (found_r) begin
          alc_we = 1'b1;  alc_waddr = bstart_r;  alc_wdata = {1'b1, need_r};
          res_st_nxt  = bfea_pkg::ST_OK;
          res_off_nxt = {1'b0, bstart_r + AW'(1), 4'd0};
          if (bstart_r == '1) res_off_nxt = OW'(1) << (AW + 4);
          res_g_nxt   = need_r;
          if (bdelta_r != '0) begin
            ext_we = 1'b1;  ext_waddr = best_r;
            ext_wdata = '{start: bstart_r + need_r[AW-1:0], len: bdelta_r};
          end
        end
      end
      bfea_pkg::S_SHDN: begin
        // pull the following entries down by one
        if (dv_r) begin
          ext_we = 1'b1;  ext_waddr = daddr_r - EW'(1);  ext_wdata = ext_rdata;
        end
        if (scan_end) cnt_nxt = cnt_r - CW'(1);
      end
      bfea_pkg::S_FCHK: begin
        size_nxt = alc_rdata[LW-1:0];
      end
      bfea_pkg::S_FWALK: begin
        if (dv_r) begin
          if (ext_rdata.start < gi_r) begin
            lt_nxt = lt_r + CW'(1);  prev_nxt = ext_rdata;
          end else if (!hnext_r) begin
            hnext_nxt = 1'b1;  next_nxt = ext_rdata;
          end
        end
      end
      bfea_pkg::S_FDEC: begin
        ridx_nxt = cnt_r;
        res_st_nxt = bfea_pkg::ST_OK;  res_off_nxt = off_r;  res_g_nxt = size_r;
        if (prev_hit) begin
          ext_we = 1'b1;  ext_waddr = EW'(lt_r - CW'(1));
          ext_wdata = '{start: prev_r.start, len: prev_r.len + size_r};
          alc_we = 1'b1;
        end else if (next_hit) begin
          ext_we = 1'b1;  ext_waddr = EW'(lt_r);
          ext_wdata = '{start: gi_r, len: next_r.len + size_r};
          alc_we = 1'b1;
        end else if (cnt_r >= CW'(bfea_pkg::EXT_DEPTH)) begin
          res_st_nxt = bfea_pkg::ST_TABLE_FULL;  res_off_nxt = '0;  res_g_nxt = '0;
        end
      end
      bfea_pkg::S_SHUP: begin
        // push entries up by one, then drop the new extent in the gap
        if (dv_r) begin
          ext_we = 1'b1;  ext_waddr = daddr_r + EW'(1);  ext_wdata = ext_rdata;
        end else if (scan_end) begin
          ext_we = 1'b1;  ext_waddr = EW'(lt_r);
          ext_wdata = '{start: gi_r, len: size_r};
          cnt_nxt = cnt_r + CW'(1);
          alc_we = 1'b1;
        end
      end
      bfea_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_off_nxt = res_off_r;  out_g_nxt = res_g_r;  out_st_nxt = res_st_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfea_pkg::S_CLEAR;
      clr_r       <= '0;
      heap_r      <= LW'(bfea_pkg::HEAP_GRANULES);
      cnt_r       <= CW'(1);
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      heap_r      <= heap_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    need_r <= need_nxt;  off_r <= off_nxt;  gi_r <= gi_nxt;  size_r <= size_nxt;
    ridx_r <= ridx_nxt;  daddr_r <= daddr_nxt;
    found_r <= found_nxt;  exact_r <= exact_nxt;  best_r <= best_nxt;
    bstart_r <= bstart_nxt;  bdelta_r <= bdelta_nxt;  lt_r <= lt_nxt;
    prev_r <= prev_nxt;  next_r <= next_nxt;  hnext_r <= hnext_nxt;
    res_off_r <= res_off_nxt;  res_g_r <= res_g_nxt;  res_st_r <= res_st_nxt;
    out_off_r <= out_off_nxt;  out_g_r <= out_g_nxt;  out_st_r <= out_st_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_user_offset      = out_off_r;
  assign out_granted_granules = out_g_r;
  assign out_status           = out_st_r;

endmodule

>>> sv/bfea_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module bfea_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bfea_checker.sv
// port-level checks for the best-fit extent allocator, with its bind
// depends on bfea_pkg and best_fit_extent_allocator_core
module bfea_props (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bfea_pkg::OFF_W-1:0]   out_user_offset,
  input logic [bfea_pkg::LEN_W-1:0]   out_granted_granules,
  input logic [1:0]                   out_status
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // failed requests carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bfea_pkg::ST_OK |->
      out_user_offset == '0 && out_granted_granules == '0)
    else $error("failure result with non-zero fields");

  // granted offsets are granule aligned and past the header
  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bfea_pkg::ST_OK |->
      out_user_offset[3:0] == 4'd0 && out_user_offset != '0 &&
      out_granted_granules != '0)
    else $error("bad offset or size on ok result");

endmodule

bind best_fit_extent_allocator_core bfea_props u_bfea_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_user_offset(out_user_offset),
  .out_granted_granules(out_granted_granules), .out_status(out_status)
);
